// ----- design/dwsr_pkg.sv -----
package dwsr_pkg;

  localparam int SPEED_FRAC_BITS = 8;
  localparam int SPEED_W = 25;
  localparam int REQ_W = 16;
  localparam int MAG_W = 16;
  localparam int TIME_W = 32;

  // Shared multiplier operands: 20 bits by 16 bits.
  localparam int MUL_A_W = 20;
  localparam int MUL_B_W = 16;
  localparam int PROD_W = MUL_A_W + MUL_B_W;
  localparam int DIVIDEND_W = PROD_W + SPEED_FRAC_BITS;
  localparam int QUOT_W = 24;
  localparam int REM_W = DIVIDEND_W - QUOT_W;
  localparam int CNT_W = $clog2(QUOT_W);

  localparam int CAP_W = 15;
  localparam logic [CAP_W-1:0] ELAPSED_CAP_US = 15'd20000;
  localparam logic [REM_W-1:0] US_PER_SECOND = 20'd1000000;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 20;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MOTION_THRESHOLD = 3'd0,
    CFG_MAX_STEPS        = 3'd1,
    CFG_DRIVE_SCALE      = 3'd2,
    CFG_ACCELERATION     = 3'd3,
    CFG_RAMP_INTERVAL    = 3'd4,
    CFG_INVERT_LEFT      = 3'd5,
    CFG_INVERT_RIGHT     = 3'd6
  } cfg_idx_e;

  typedef enum logic [1:0] {
    CMD_DRIVE = 2'd0,
    CMD_TICK  = 2'd1,
    CMD_STOP  = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_MUL,
    ST_DIV,
    ST_APPLY,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [14:0] motion_threshold;
    logic [15:0] max_steps_per_second;
    logic [14:0] drive_scale;
    logic [19:0] acceleration;
    logic [19:0] ramp_interval_us;
    logic        invert_left;
    logic        invert_right;
  } cfg_t;

  typedef struct packed {
    logic load_in;
    logic decode;
    logic stop;
    logic mul_load;
    logic div_step;
    logic apply_drive;
    logic apply_ramp;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       tick_due;
    logic       out_free;
  } dp_status_t;

endpackage

// ----- design/dwsr_ctrl.sv -----
module dwsr_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  dwsr_pkg::dp_status_t status_i,
  output dwsr_pkg::dp_cmd_t    ctrl_cmd_o
);
  import dwsr_pkg::*;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    ctrl_cmd_o = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          ctrl_cmd_o.load_in = 1'b1;
          state_d = ST_DECODE;
        end
      end
      ST_DECODE: begin
        ctrl_cmd_o.decode = 1'b1;
        case (status_i.cmd)
          CMD_DRIVE, CMD_TICK: state_d = ST_MUL;
          CMD_STOP: begin
            ctrl_cmd_o.stop = 1'b1;
            state_d = ST_DONE;
          end
          default: state_d = ST_DONE;
        endcase
      end
      ST_MUL: begin
        // A tick that comes before the interval has run out changes nothing.
        if (status_i.cmd == CMD_TICK && !status_i.tick_due) begin
          state_d = ST_DONE;
        end else begin
          ctrl_cmd_o.mul_load = 1'b1;
          cnt_d = '0;
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        ctrl_cmd_o.div_step = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(QUOT_W - 1)) begin
          state_d = ST_APPLY;
        end
      end
      ST_APPLY: begin
        if (status_i.cmd == CMD_DRIVE) begin
          ctrl_cmd_o.apply_drive = 1'b1;
        end else begin
          ctrl_cmd_o.apply_ramp = 1'b1;
        end
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (status_i.out_free) begin
          ctrl_cmd_o.load_out = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign in_stall_o = (state_q != ST_IDLE);

  a_cmd_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({ctrl_cmd_o.stop, ctrl_cmd_o.mul_load, ctrl_cmd_o.div_step,
              ctrl_cmd_o.apply_drive, ctrl_cmd_o.apply_ramp, ctrl_cmd_o.load_out}))
    else $error("datapath commands overlap");

  a_div_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV && cnt_q == CNT_W'(QUOT_W - 1)) |=> state_q == ST_APPLY)
    else $error("division did not end after the last quotient bit");

  a_div_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIV |-> ($past(state_q) == ST_MUL || $past(state_q) == ST_DIV))
    else $error("division entered without loading the product");

endmodule

// ----- design/dwsr_datapath.sv -----
module dwsr_datapath (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  dwsr_pkg::cfg_t                         cfg_i,
  input  dwsr_pkg::dp_cmd_t                      ctrl_cmd_i,
  output dwsr_pkg::dp_status_t                   status_o,
  input  logic [1:0]                             command_i,
  input  logic signed [dwsr_pkg::REQ_W-1:0]      left_request_i,
  input  logic signed [dwsr_pkg::REQ_W-1:0]      right_request_i,
  input  logic [dwsr_pkg::TIME_W-1:0]            now_us_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic signed [dwsr_pkg::SPEED_W-1:0]    left_speed_o,
  output logic signed [dwsr_pkg::SPEED_W-1:0]    right_speed_o,
  output logic                                   left_enabled_o,
  output logic                                   right_enabled_o,
  output logic                                   ramp_updated_o
);
  import dwsr_pkg::*;

  // Returns {negative, magnitude} of a request after the optional inversion.
  function automatic logic [MAG_W:0] req_mag(logic signed [REQ_W-1:0] r, logic inv);
    logic signed [REQ_W:0] v;
    logic                  neg;
    v = {r[REQ_W-1], r};
    if (inv) begin
      v = (r == {1'b1, {(REQ_W-1){1'b0}}}) ? {2'b00, {(REQ_W-1){1'b1}}} : -v;
    end
    neg = v[REQ_W];
    return {neg, neg ? MAG_W'(-v) : v[MAG_W-1:0]};
  endfunction

  // One restoring division step: returns {remainder, shifted dividend/quotient}.
  function automatic logic [REM_W+QUOT_W-1:0] div_step(logic [REM_W-1:0] rem,
                                                       logic [QUOT_W-1:0] low,
                                                       logic [REM_W-1:0] dvs);
    logic [REM_W:0] sh;
    logic [REM_W:0] diff;
    logic           q;
    sh   = {rem, low[QUOT_W-1]};
    diff = sh - {1'b0, dvs};
    q    = (sh >= {1'b0, dvs});
    return {q ? diff[REM_W-1:0] : sh[REM_W-1:0], low[QUOT_W-2:0], q};
  endfunction

  function automatic logic signed [SPEED_W-1:0] target_of(logic [MAG_W-1:0] mag,
                                                          logic neg,
                                                          logic [QUOT_W-1:0] quot,
                                                          cfg_t cfg);
    logic [QUOT_W-1:0]         limit;
    logic [QUOT_W-1:0]         t;
    logic signed [SPEED_W-1:0] st;
    limit = {cfg.max_steps_per_second, {SPEED_FRAC_BITS{1'b0}}};
    // Also covers a zero drive scale, which saturates to full scale.
    t  = (mag >= {1'b0, cfg.drive_scale}) ? limit : quot;
    st = {1'b0, t};
    return neg ? -st : st;
  endfunction

  // Moves the current speed toward the target by delta without overshoot.
  function automatic logic signed [SPEED_W-1:0] ramp_to(logic signed [SPEED_W-1:0] cur,
                                                        logic signed [SPEED_W-1:0] tgt,
                                                        logic [QUOT_W-1:0] delta);
    logic signed [SPEED_W:0] c;
    logic signed [SPEED_W:0] t;
    logic signed [SPEED_W:0] d;
    logic signed [SPEED_W:0] up;
    logic signed [SPEED_W:0] dn;
    logic signed [SPEED_W:0] res;
    c   = {cur[SPEED_W-1], cur};
    t   = {tgt[SPEED_W-1], tgt};
    d   = {2'b00, delta};
    up  = c + d;
    dn  = c - d;
    res = c;
    if (c < t) begin
      res = (up > t) ? t : up;
    end else if (c > t) begin
      res = (dn < t) ? t : dn;
    end
    return res[SPEED_W-1:0];
  endfunction

  // Latched transaction.
  logic [1:0]               cmd_q;
  logic signed [REQ_W-1:0]  left_req_q, right_req_q;
  logic [TIME_W-1:0]        now_q;

  // Decoded operands.
  logic [MAG_W-1:0]         mag_l_q, mag_r_q;
  logic                     neg_l_q, neg_r_q;
  logic [CAP_W-1:0]         capped_q;
  logic                     due_q;

  // Divider lanes.
  logic [REM_W-1:0]         rem_l_q, rem_r_q;
  logic [QUOT_W-1:0]        low_l_q, low_r_q;

  // Wheel state.
  logic signed [SPEED_W-1:0] tgt_l_q, tgt_l_d, tgt_r_q, tgt_r_d;
  logic signed [SPEED_W-1:0] cur_l_q, cur_l_d, cur_r_q, cur_r_d;
  logic                      on_l_q, on_l_d, on_r_q, on_r_d;
  logic [TIME_W-1:0]         last_q, last_d;
  logic                      ramp_q, ramp_d;

  // Output register.
  logic                      out_valid_q;
  logic signed [SPEED_W-1:0] out_left_q, out_right_q;
  logic                      out_left_on_q, out_right_on_q, out_ramp_q;

  logic [MAG_W:0]            dec_l, dec_r;
  logic [TIME_W-1:0]         elapsed;
  logic                      is_tick;
  logic [MUL_A_W-1:0]        mul_a_l;
  logic [MUL_B_W-1:0]        mul_b_l;
  logic [PROD_W-1:0]         prod_l, prod_r;
  logic [DIVIDEND_W-1:0]     dvd_l, dvd_r;
  logic [REM_W-1:0]          divisor_l, divisor_r;
  logic [REM_W+QUOT_W-1:0]   step_l, step_r;
  logic                      neutral_l, neutral_r;

  assign is_tick  = (cmd_q == CMD_TICK);
  assign dec_l    = req_mag(left_req_q, cfg_i.invert_left);
  assign dec_r    = req_mag(right_req_q, cfg_i.invert_right);
  assign elapsed  = now_q - last_q;

  // The left lane also computes the ramp step on a tick.
  assign mul_a_l  = is_tick ? cfg_i.acceleration : {{(MUL_A_W-MAG_W){1'b0}}, mag_l_q};
  assign mul_b_l  = is_tick ? {1'b0, capped_q} : cfg_i.max_steps_per_second;
  assign prod_l   = mul_a_l * mul_b_l;
  assign prod_r   = {{(MUL_A_W-MAG_W){1'b0}}, mag_r_q} * cfg_i.max_steps_per_second;
  assign dvd_l    = {prod_l, {SPEED_FRAC_BITS{1'b0}}};
  assign dvd_r    = {prod_r, {SPEED_FRAC_BITS{1'b0}}};

  assign divisor_l = is_tick ? US_PER_SECOND
                             : {{(REM_W-15){1'b0}}, cfg_i.drive_scale};
  assign divisor_r = {{(REM_W-15){1'b0}}, cfg_i.drive_scale};
  assign step_l    = div_step(rem_l_q, low_l_q, divisor_l);
  assign step_r    = div_step(rem_r_q, low_r_q, divisor_r);

  assign neutral_l = (mag_l_q <= {1'b0, cfg_i.motion_threshold});
  assign neutral_r = (mag_r_q <= {1'b0, cfg_i.motion_threshold});

  always_ff @(posedge clk_i) begin
    if (ctrl_cmd_i.load_in) begin
      cmd_q       <= command_i;
      left_req_q  <= left_request_i;
      right_req_q <= right_request_i;
      now_q       <= now_us_i;
    end
    if (ctrl_cmd_i.decode) begin
      neg_l_q  <= dec_l[MAG_W];
      mag_l_q  <= dec_l[MAG_W-1:0];
      neg_r_q  <= dec_r[MAG_W];
      mag_r_q  <= dec_r[MAG_W-1:0];
      capped_q <= (elapsed < {{(TIME_W-CAP_W){1'b0}}, ELAPSED_CAP_US})
                  ? elapsed[CAP_W-1:0] : ELAPSED_CAP_US;
    end
    if (ctrl_cmd_i.mul_load) begin
      rem_l_q <= dvd_l[DIVIDEND_W-1:QUOT_W];
      low_l_q <= dvd_l[QUOT_W-1:0];
      rem_r_q <= dvd_r[DIVIDEND_W-1:QUOT_W];
      low_r_q <= dvd_r[QUOT_W-1:0];
    end else if (ctrl_cmd_i.div_step) begin
      {rem_l_q, low_l_q} <= step_l;
      {rem_r_q, low_r_q} <= step_r;
    end
    if (ctrl_cmd_i.load_out) begin
      out_left_q     <= cur_l_q;
      out_right_q    <= cur_r_q;
      out_left_on_q  <= on_l_q;
      out_right_on_q <= on_r_q;
      out_ramp_q     <= ramp_q;
    end
  end

  always_comb begin
    tgt_l_d = tgt_l_q;
    tgt_r_d = tgt_r_q;
    cur_l_d = cur_l_q;
    cur_r_d = cur_r_q;
    on_l_d  = on_l_q;
    on_r_d  = on_r_q;
    last_d  = last_q;
    ramp_d  = ramp_q;
    if (ctrl_cmd_i.load_in) begin
      ramp_d = 1'b0;
    end
    if (ctrl_cmd_i.stop) begin
      tgt_l_d = '0;
      tgt_r_d = '0;
      cur_l_d = '0;
      cur_r_d = '0;
      on_l_d  = 1'b0;
      on_r_d  = 1'b0;
    end
    if (ctrl_cmd_i.apply_drive) begin
      // A neutral request only releases a wheel that has already stopped.
      if (neutral_l) begin
        tgt_l_d = '0;
        if (cur_l_q == '0) on_l_d = 1'b0;
      end else begin
        tgt_l_d = target_of(mag_l_q, neg_l_q, low_l_q, cfg_i);
        on_l_d  = 1'b1;
      end
      if (neutral_r) begin
        tgt_r_d = '0;
        if (cur_r_q == '0) on_r_d = 1'b0;
      end else begin
        tgt_r_d = target_of(mag_r_q, neg_r_q, low_r_q, cfg_i);
        on_r_d  = 1'b1;
      end
    end
    if (ctrl_cmd_i.apply_ramp) begin
      cur_l_d = ramp_to(cur_l_q, tgt_l_q, low_l_q);
      cur_r_d = ramp_to(cur_r_q, tgt_r_q, low_l_q);
      if (tgt_l_q == '0 && cur_l_d == '0) on_l_d = 1'b0;
      if (tgt_r_q == '0 && cur_r_d == '0) on_r_d = 1'b0;
      last_d = now_q;
      ramp_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tgt_l_q     <= '0;
      tgt_r_q     <= '0;
      cur_l_q     <= '0;
      cur_r_q     <= '0;
      on_l_q      <= 1'b0;
      on_r_q      <= 1'b0;
      last_q      <= '0;
      ramp_q      <= 1'b0;
      due_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      tgt_l_q <= tgt_l_d;
      tgt_r_q <= tgt_r_d;
      cur_l_q <= cur_l_d;
      cur_r_q <= cur_r_d;
      on_l_q  <= on_l_d;
      on_r_q  <= on_r_d;
      last_q  <= last_d;
      ramp_q  <= ramp_d;
      if (ctrl_cmd_i.decode) begin
        due_q <= (elapsed >= {{(TIME_W-20){1'b0}}, cfg_i.ramp_interval_us});
      end
      if (ctrl_cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign status_o.cmd      = cmd_q;
  assign status_o.tick_due = due_q;
  assign status_o.out_free = !out_valid_q || !out_stall_i;

  assign out_valid_o     = out_valid_q;
  assign left_speed_o    = out_left_q;
  assign right_speed_o   = out_right_q;
  assign left_enabled_o  = out_left_on_q;
  assign right_enabled_o = out_right_on_q;
  assign ramp_updated_o  = out_ramp_q;

  a_left_off_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !on_l_q |-> (cur_l_q == '0 && tgt_l_q == '0))
    else $error("left wheel disabled while it still moves or has a target");

  a_right_off_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !on_r_q |-> (cur_r_q == '0 && tgt_r_q == '0))
    else $error("right wheel disabled while it still moves or has a target");

  a_ramp_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_cmd_i.apply_ramp |=> (last_q == $past(now_q) && ramp_q))
    else $error("ramp update did not record its time");

  a_stop_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_cmd_i.stop |=> (cur_l_q == '0 && cur_r_q == '0 && !on_l_q && !on_r_q))
    else $error("stop did not clear the wheels");

endmodule

// ----- design/dual_wheel_speed_ramp.sv -----
// Two-wheel speed ramp. Each input transaction is a drive request, a time tick
// carrying a free-running microsecond count, or a stop, and each produces exactly
// one result transaction with both current speeds (signed, 8 fraction bits), both
// enable flags and a flag telling whether a tick ramped. One transaction is
// processed at a time: a drive request or a due tick passes decode, the multiplier
// load, the 24-step restoring divider that scales requests and computes the ramp
// step, and the apply step before the result register; a tick that is not due yet,
// a stop or an unknown command skips the divider. The result register lets the
// next transaction be accepted while the previous result is still stalled.
// The configuration port must be written only while the block is idle.
module dual_wheel_speed_ramp (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [dwsr_pkg::CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [dwsr_pkg::CFG_DATA_W-1:0]        cfg_wdata_i,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic [1:0]                             command_i,
  input  logic signed [dwsr_pkg::REQ_W-1:0]      left_request_i,
  input  logic signed [dwsr_pkg::REQ_W-1:0]      right_request_i,
  input  logic [dwsr_pkg::TIME_W-1:0]            now_us_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic signed [dwsr_pkg::SPEED_W-1:0]    left_speed_o,
  output logic signed [dwsr_pkg::SPEED_W-1:0]    right_speed_o,
  output logic                                   left_enabled_o,
  output logic                                   right_enabled_o,
  output logic                                   ramp_updated_o
);
  import dwsr_pkg::*;

  cfg_t       cfg_q;
  dp_cmd_t    ctrl_cmd;
  dp_status_t dp_status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{motion_threshold:     15'd0,
                 max_steps_per_second: 16'd1000,
                 drive_scale:          15'd1000,
                 acceleration:         20'd2000,
                 ramp_interval_us:     20'd1000,
                 invert_left:          1'b0,
                 invert_right:         1'b0};
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MOTION_THRESHOLD: cfg_q.motion_threshold     <= cfg_wdata_i[14:0];
        CFG_MAX_STEPS:        cfg_q.max_steps_per_second <= cfg_wdata_i[15:0];
        CFG_DRIVE_SCALE:      cfg_q.drive_scale          <= cfg_wdata_i[14:0];
        CFG_ACCELERATION:     cfg_q.acceleration         <= cfg_wdata_i[19:0];
        CFG_RAMP_INTERVAL:    cfg_q.ramp_interval_us     <= cfg_wdata_i[19:0];
        CFG_INVERT_LEFT:      cfg_q.invert_left          <= cfg_wdata_i[0];
        CFG_INVERT_RIGHT:     cfg_q.invert_right         <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  dwsr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (dp_status),
    .ctrl_cmd_o (ctrl_cmd)
  );

  dwsr_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .ctrl_cmd_i      (ctrl_cmd),
    .status_o        (dp_status),
    .command_i       (command_i),
    .left_request_i  (left_request_i),
    .right_request_i (right_request_i),
    .now_us_i        (now_us_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .left_speed_o    (left_speed_o),
    .right_speed_o   (right_speed_o),
    .left_enabled_o  (left_enabled_o),
    .right_enabled_o (right_enabled_o),
    .ramp_updated_o  (ramp_updated_o)
  );

endmodule
